// ===== design/cartridge_bank_mapper_with_irq_assert.svh =====
// assertion macros shared by the mapper checker
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_ASSERT_SVH

// same-cycle implication, off while reset is held
`define CBM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also runs during reset
`define CBM_ASSERT_NEXT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cbm_pkg.sv =====
// types and constants of the cartridge bank mapper
package cbm_pkg;

    // field and bank widths
    localparam int FUNC_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int TGT_W    = 3;
    localparam int MADDR_W  = 21;
    localparam int BANK_W   = 8;
    localparam int CNT_W    = 9;
    localparam int OFF_W    = 13;
    localparam int PAT_OFF_W = 10;
    localparam int WIN_W    = 3;
    localparam int IRQ_W    = 15;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 1'd1;

    // reset values
    localparam logic [CNT_W-1:0] PRG_COUNT_RST = 9'd32;
    localparam logic [CNT_W-1:0] CHR_COUNT_RST = 9'd256;
    localparam logic [CNT_W-1:0] COUNT_MAX     = 9'd256;

    // cpu address decode on address bits 15..11
    localparam logic [4:0] SEL_IRQ_LO = 5'b01010;
    localparam logic [4:0] SEL_IRQ_HI = 5'b01011;
    localparam logic [4:0] SEL_PRG0   = 5'b11100;
    localparam logic [4:0] SEL_PRG1   = 5'b11101;
    localparam logic [4:0] SEL_PRG2   = 5'b11110;
    localparam logic [2:0] SEL_PRG_RAM = 3'b011;
    localparam logic [1:0] SEL_CHR_REG = 2'b10;
    localparam logic [1:0] PRG_FIXED_WIN = 2'd3;

    localparam logic [BANK_W-1:0] NT_BANK_MIN = 8'hE0;
    localparam logic [IRQ_W-1:0]  IRQ_MAX     = 15'h7FFF;

    typedef enum logic [FUNC_W-1:0] {
        FN_CPU_RD = 3'd0,
        FN_CPU_WR = 3'd1,
        FN_PAT_RD = 3'd2,
        FN_PAT_WR = 3'd3,
        FN_TICK   = 3'd4
    } func_t;

    typedef enum logic [TGT_W-1:0] {
        TGT_NONE      = 3'd0,
        TGT_PRG_RAM   = 3'd1,
        TGT_PRG_ROM   = 3'd2,
        TGT_PATTERN   = 3'd3,
        TGT_NAMETABLE = 3'd4
    } target_t;

    // classified operation passed from front to back
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PRG_RAM_RD,
        OP_PRG_RAM_WR,
        OP_PRG_ROM_RD,
        OP_IRQ_LO,
        OP_IRQ_HI,
        OP_CHR_BANK,
        OP_PRG_BANK,
        OP_PAT_RD,
        OP_PAT_WR,
        OP_TICK
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        func_t               func;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   data;
    } in_item_t;

    typedef struct packed {
        target_t             target;
        logic [MADDR_W-1:0]  mapped_address;
        logic                write_enable;
        logic                irq;
    } out_item_t;

    typedef struct packed {
        op_t                 op;
        logic [WIN_W-1:0]    win;
        logic [OFF_W-1:0]    offset;
        logic [DATA_W-1:0]   data;
    } qitem_t;

endpackage

// ===== design/cbm_front.sv =====
// front end: classifies each incoming beat into a mapper operation
module cbm_front import cbm_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     push_valid,
    input  logic     push_ready,
    output qitem_t   push_item
);

    logic [ADDR_W-1:0] addr;
    logic [4:0]        sel;

    assign addr       = s_item.address;
    assign sel        = addr[15:11];
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

    // decode function and address into an operation with window and offset
    always_comb begin
        push_item.op     = OP_NONE;
        push_item.win    = '0;
        push_item.offset = addr[OFF_W-1:0];
        push_item.data   = s_item.data;
        unique case (s_item.func)
            FN_CPU_RD: begin
                if (addr[15:13] == SEL_PRG_RAM) begin
                    push_item.op = OP_PRG_RAM_RD;
                end else if (addr[15]) begin
                    push_item.op  = OP_PRG_ROM_RD;
                    push_item.win = {1'b0, addr[14:13]};
                end
            end
            FN_CPU_WR: begin
                if (addr[15:13] == SEL_PRG_RAM) begin
                    push_item.op = OP_PRG_RAM_WR;
                end else if (sel == SEL_IRQ_LO) begin
                    push_item.op = OP_IRQ_LO;
                end else if (sel == SEL_IRQ_HI) begin
                    push_item.op = OP_IRQ_HI;
                end else if (addr[15:14] == SEL_CHR_REG) begin
                    push_item.op  = OP_CHR_BANK;
                    push_item.win = addr[13:11];
                end else if (sel == SEL_PRG0 || sel == SEL_PRG1 || sel == SEL_PRG2) begin
                    push_item.op  = OP_PRG_BANK;
                    push_item.win = {1'b0, addr[12:11]};
                end
            end
            FN_PAT_RD: begin
                push_item.op  = OP_PAT_RD;
                push_item.win = addr[12:10];
            end
            FN_PAT_WR: begin
                push_item.op  = OP_PAT_WR;
                push_item.win = addr[12:10];
            end
            FN_TICK: begin
                push_item.op = OP_TICK;
            end
            default: begin
                push_item.op = OP_NONE;
            end
        endcase
    end

endmodule

// ===== design/cbm_queue.sv =====
// small fifo between front and back
module cbm_queue import cbm_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  qitem_t wr_item,
    output logic   rd_valid,
    input  logic   rd_ready,
    output qitem_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    qitem_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;
    logic               do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_QW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + CNT_QW'(1);
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== design/cbm_mod.sv =====
// iterative remainder unit, one quotient bit per cycle
module cbm_mod import cbm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [BANK_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [BANK_W-1:0] remainder
);

    localparam int STEP_W = $clog2(BANK_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BANK_W - 1);

    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [BANK_W-1:0] dvd_reg, rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  trial;
    logic [BANK_W-1:0] rem_next;

    // restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {rem_reg, dvd_reg[BANK_W-1]};
        if (trial >= div_reg) begin
            rem_next = BANK_W'(trial - div_reg);
        end else begin
            rem_next = trial[BANK_W-1:0];
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[BANK_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/cbm_back.sv =====
// back end: bank state, irq counter, address mapping and result register
module cbm_back import cbm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_write_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  qitem_t               q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    bk_state_t          state_reg, state_next;
    logic [BANK_W-1:0]  prg_bank_reg [3];
    logic [BANK_W-1:0]  pat_bank_reg [8];
    logic [7:0]         pat_nt_reg;
    logic [IRQ_W-1:0]   irq_count_reg, irq_inc;
    logic               irq_counting_reg, irq_pending_reg;
    logic [CNT_W-1:0]   prg_count_reg, chr_count_reg;
    logic [CNT_W-1:0]   prg_cnt, chr_cnt;

    target_t            res_target_reg;
    logic [MADDR_W-1:0] res_addr_reg;
    logic               res_we_reg;
    logic [OFF_W-1:0]   res_offset_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_item_reg;

    logic               pop_fire, slot_free, load_out, mod_start, mod_done;
    logic               need_div;
    target_t            exe_target;
    logic [MADDR_W-1:0] exe_addr;
    logic               exe_we;
    logic [BANK_W-1:0]  div_dividend, mod_rem, prg_sel_bank, pat_sel_bank;
    logic [CNT_W-1:0]   div_divisor;
    logic [CNT_W-1:0]   prg_last;
    logic               pat_sel_nt;
    logic [MADDR_W-1:0] div_addr;

    // bank counts above 256 act as 256
    assign prg_cnt  = (prg_count_reg > COUNT_MAX) ? COUNT_MAX : prg_count_reg;
    assign chr_cnt  = (chr_count_reg > COUNT_MAX) ? COUNT_MAX : chr_count_reg;
    assign prg_last = prg_cnt - CNT_W'(1);
    assign irq_inc  = irq_count_reg + IRQ_W'(1);

    // window bank selection
    always_comb begin
        case (q_item.win[1:0])
            2'd0:    prg_sel_bank = prg_bank_reg[0];
            2'd1:    prg_sel_bank = prg_bank_reg[1];
            default: prg_sel_bank = prg_bank_reg[2];
        endcase
        pat_sel_bank = pat_bank_reg[q_item.win];
        pat_sel_nt   = pat_nt_reg[q_item.win];
    end

    // mapping of the item at the queue head
    always_comb begin
        need_div     = 1'b0;
        exe_target   = TGT_NONE;
        exe_addr     = '0;
        exe_we       = 1'b0;
        div_dividend = prg_sel_bank;
        div_divisor  = prg_cnt;
        unique case (q_item.op)
            OP_PRG_RAM_RD, OP_PRG_RAM_WR: begin
                exe_target = TGT_PRG_RAM;
                exe_addr   = MADDR_W'(q_item.offset);
                exe_we     = (q_item.op == OP_PRG_RAM_WR);
            end
            OP_PRG_ROM_RD: begin
                if (prg_cnt != '0) begin
                    exe_target = TGT_PRG_ROM;
                    if (q_item.win[1:0] == PRG_FIXED_WIN) begin
                        exe_addr = {prg_last[BANK_W-1:0], q_item.offset};
                    end else begin
                        need_div = 1'b1;
                    end
                end
            end
            OP_PAT_RD, OP_PAT_WR: begin
                if (pat_sel_nt) begin
                    if (q_item.op == OP_PAT_RD) begin
                        exe_target = TGT_NAMETABLE;
                        exe_addr   = MADDR_W'({pat_sel_bank[0], q_item.offset[PAT_OFF_W-1:0]});
                    end
                end else if (chr_cnt != '0) begin
                    exe_target   = TGT_PATTERN;
                    exe_we       = (q_item.op == OP_PAT_WR);
                    need_div     = 1'b1;
                    div_dividend = pat_sel_bank;
                    div_divisor  = chr_cnt;
                end
            end
            default: begin
                exe_target = TGT_NONE;
            end
        endcase
    end

    // bank remainder joins the window offset
    always_comb begin
        if (res_target_reg == TGT_PRG_ROM) begin
            div_addr = {mod_rem, res_offset_reg};
        end else begin
            div_addr = MADDR_W'({mod_rem, res_offset_reg[PAT_OFF_W-1:0]});
        end
    end

    cbm_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = need_div ? BK_DIV : BK_EMIT;
                end
            end
            BK_DIV: begin
                if (mod_done) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (slot_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        slot_free    = !m_valid_reg || m_ready;
        q_ready      = (state_reg == BK_IDLE);
        pop_fire     = q_ready && q_valid;
        mod_start    = pop_fire && need_div;
        load_out     = (state_reg == BK_EMIT) && slot_free;
        m_valid_next = load_out || (m_valid_reg && !m_ready);
    end

    // control, bank and irq state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= BK_IDLE;
            m_valid_reg      <= 1'b0;
            prg_count_reg    <= PRG_COUNT_RST;
            chr_count_reg    <= CHR_COUNT_RST;
            irq_count_reg    <= '0;
            irq_counting_reg <= 1'b0;
            irq_pending_reg  <= 1'b0;
            pat_nt_reg       <= '0;
            for (int i = 0; i < 3; i++) begin
                prg_bank_reg[i] <= BANK_W'(i);
            end
            for (int i = 0; i < 8; i++) begin
                pat_bank_reg[i] <= BANK_W'(i);
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write_en) begin
                if (cfg_index == CFG_PRG_COUNT) begin
                    prg_count_reg <= cfg_write_data;
                end else if (cfg_index == CFG_CHR_COUNT) begin
                    chr_count_reg <= cfg_write_data;
                end
            end
            if (pop_fire) begin
                case (q_item.op)
                    OP_IRQ_LO: begin
                        irq_count_reg[7:0] <= q_item.data;
                        irq_pending_reg    <= 1'b0;
                    end
                    OP_IRQ_HI: begin
                        irq_count_reg[IRQ_W-1:8] <= q_item.data[6:0];
                        irq_counting_reg         <= q_item.data[7];
                        irq_pending_reg          <= 1'b0;
                    end
                    OP_CHR_BANK: begin
                        pat_bank_reg[q_item.win] <= q_item.data;
                        pat_nt_reg[q_item.win]   <= (q_item.data >= NT_BANK_MIN);
                    end
                    OP_PRG_BANK: begin
                        case (q_item.win[1:0])
                            2'd0:    prg_bank_reg[0] <= q_item.data;
                            2'd1:    prg_bank_reg[1] <= q_item.data;
                            default: prg_bank_reg[2] <= q_item.data;
                        endcase
                    end
                    OP_TICK: begin
                        if (irq_counting_reg && irq_count_reg != IRQ_MAX) begin
                            irq_count_reg <= irq_inc;
                            if (irq_inc == IRQ_MAX) begin
                                irq_pending_reg <= 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result staging and output register
    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            res_target_reg <= exe_target;
            res_addr_reg   <= exe_addr;
            res_we_reg     <= exe_we;
            res_offset_reg <= q_item.offset;
        end else if (state_reg == BK_DIV && mod_done) begin
            res_addr_reg <= div_addr;
        end
        if (load_out) begin
            m_item_reg.target         <= res_target_reg;
            m_item_reg.mapped_address <= res_addr_reg;
            m_item_reg.write_enable   <= res_we_reg;
            m_item_reg.irq            <= irq_pending_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== design/cartridge_bank_mapper_with_irq.sv =====
// top level of the cartridge bank mapper with cycle irq counter
// Translates each CPU or pattern-bus access (or CPU tick) into a target memory and a
// byte address there, one result beat per input beat, in order. The front decodes the
// beat and places it in a small queue; the back works through the queue one beat at a
// time. A beat that needs no bank reduction is popped, then loaded into the output
// register. Switchable program ROM windows and pattern ROM/RAM windows reduce the
// bank number modulo the bank count in a shared remainder unit that takes one bit
// per cycle. Up to QUEUE_DEPTH beats are taken while the back is busy, and a finished
// result waits in the output register without blocking the queue. The user must write
// bank counts through the cfg port only while the block is idle; the block does not
// enforce this. Index 0 is the program ROM bank count, index 1 the pattern bank count.
module cartridge_bank_mapper_with_irq import cbm_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_write_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    logic   push_valid, push_ready, pop_valid, pop_ready;
    qitem_t push_item, pop_item;

    // decode
    cbm_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue
    cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    // execution
    cbm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_item         (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item)
    );

endmodule

// ===== design/cbm_checker.sv =====
// port checker for the mapper, bound to the top level
`include "cartridge_bank_mapper_with_irq_assert.svh"

module cbm_checker import cbm_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a stalled result beat holds
    `CBM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result beat changed while stalled")

    // no target means zero address and no write
    `CBM_ASSERT_NOW(a_none_zero, aclk, aresetn, m_valid && m_item.target == TGT_NONE, m_item.mapped_address == '0 && !m_item.write_enable, "target none with address or write")

    // nametable beats are reads within two 1 KB pages
    `CBM_ASSERT_NOW(a_nt_range, aclk, aresetn, m_valid && m_item.target == TGT_NAMETABLE, !m_item.write_enable && m_item.mapped_address[20:11] == '0, "nametable beat out of range")

    // reset empties the result register
    `CBM_ASSERT_NEXT_RST(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind cartridge_bank_mapper_with_irq cbm_checker u_cbm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
